// ===== sv/btmu_pkg.sv =====
`default_nettype none

package btmu_pkg;

  // Default table depth
  localparam int unsigned MAX_ENTRIES_DEF = 16;

  // Command codes
  localparam logic [2:0] FUNC_CHECK   = 3'd0;
  localparam logic [2:0] FUNC_ADD     = 3'd1;
  localparam logic [2:0] FUNC_ENABLE  = 3'd2;
  localparam logic [2:0] FUNC_DISABLE = 3'd3;
  localparam logic [2:0] FUNC_DELETE  = 3'd4;
  localparam logic [2:0] FUNC_RESUME  = 3'd5;
  localparam logic [2:0] FUNC_HALT    = 3'd6;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  // Entry kind that can fire
  localparam logic [1:0] KIND_CODE = 2'd0;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] address;
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic        all_entries;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       hit;
    logic [3:0] hit_slot;
    logic       halted;
    logic [4:0] entry_count;
  } result_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic        on;
  } entry_t;

  // Controller to datapath strobes
  typedef struct packed {
    logic load;    // capture input beat
    logic exec;    // apply command, register match vector
    logic finish;  // encode hit, load result register
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== sv/breakpoint_table_match_unit.sv =====
// Debug breakpoint table. Holds up to MAX_ENTRIES packed entries (kind, 16-bit
// address, enable) plus an entry count and a halted flag. Each input beat is
// one command: pc check, add, enable, disable, delete (with compaction, or the
// whole table when all_entries is set), resume or halt; each yields exactly one
// result beat carrying status, hit, hit_slot, halted and entry_count. Only
// enabled code breakpoints fire; read and write watch entries are stored and
// otherwise ignored. A check while halted never hits.
// One command in flight: accept, execute and finish steps, a new beat taken
// only after finish; the finish step waits while the output result register
// is still stalled. Execute compares the PC against the whole comparator
// bank in parallel and registers the match vector; finish priority-encodes it.
`default_nettype none

module breakpoint_table_match_unit #(
  parameter int unsigned MAX_ENTRIES = btmu_pkg::MAX_ENTRIES_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  // command beats
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  btmu_pkg::item_t    in_item_i,
  // result beats
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output btmu_pkg::result_t  out_result_o
);

  btmu_pkg::ctrl_cmd_t cmd;

  // sequencer: one command in flight, result register decouples the output
  btmu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // table, comparator bank, count and halted flag
  btmu_dp #(
    .MaxEntries (MAX_ENTRIES)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (in_item_i),
    .result_o (out_result_o)
  );

endmodule

`default_nettype wire

// ===== sv/btmu_ctrl.sv =====
`default_nettype none

module btmu_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output btmu_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        // wait here until the result register can take the new beat
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/btmu_dp.sv =====
`default_nettype none

module btmu_dp #(
  parameter int unsigned MaxEntries = btmu_pkg::MAX_ENTRIES_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  btmu_pkg::ctrl_cmd_t  cmd_i,
  input  btmu_pkg::item_t      item_i,
  output btmu_pkg::result_t    result_o
);

  localparam int unsigned CW = $clog2(MaxEntries + 1);
  localparam int unsigned IW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned SW = (CW > 4) ? CW : 4;

  btmu_pkg::item_t   item_q;
  btmu_pkg::entry_t  ent_q [MaxEntries];
  btmu_pkg::entry_t  ent_d [MaxEntries];
  logic [MaxEntries-1:0] match_q, match_d;
  logic [CW-1:0]     count_q, count_d;
  logic              halted_q, halted_d;
  logic [1:0]        status_q, status_d;
  btmu_pkg::result_t result_q;

  logic [SW-1:0] slot_ext;
  logic          slot_ok;
  logic          full;
  logic          hit_any;
  logic [IW-1:0] hit_idx;

  assign slot_ext = SW'(item_q.slot);
  assign slot_ok  = slot_ext < SW'(count_q);
  assign full     = (count_q == CW'(MaxEntries));

  // Per-entry next value and comparator
  for (genvar g = 0; g < MaxEntries; g++) begin : g_ent
    btmu_pkg::entry_t up;
    logic at_slot, above_slot, at_cnt, below_cnt;

    if (g < MaxEntries - 1) begin : g_shift
      assign up = ent_q[g+1];
    end else begin : g_last
      assign up = ent_q[g];
    end

    assign at_slot    = (SW'(g) == slot_ext);
    assign above_slot = (SW'(g) >= slot_ext);
    assign at_cnt     = (CW'(g) == count_q);
    assign below_cnt  = (CW'(g) < count_q);

    assign match_d[g] = (item_q.func == btmu_pkg::FUNC_CHECK) && !halted_q && below_cnt &&
                        ent_q[g].on && (ent_q[g].kind == btmu_pkg::KIND_CODE) &&
                        (ent_q[g].addr == item_q.address);

    always_comb begin
      ent_d[g] = ent_q[g];
      case (item_q.func)
        btmu_pkg::FUNC_ADD: begin
          if (!full && at_cnt) begin
            ent_d[g].kind = item_q.kind;
            ent_d[g].addr = item_q.address;
            ent_d[g].on   = 1'b1;
          end
        end
        btmu_pkg::FUNC_ENABLE, btmu_pkg::FUNC_DISABLE: begin
          // entries above the count are never read, so "all" touches every one
          if (item_q.all_entries || (slot_ok && at_slot)) begin
            ent_d[g].on = (item_q.func == btmu_pkg::FUNC_ENABLE);
          end
        end
        btmu_pkg::FUNC_DELETE: begin
          // compaction: everything from the slot upward moves down one place
          if (!item_q.all_entries && slot_ok && above_slot) begin
            ent_d[g] = up;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    count_d  = count_q;
    status_d = btmu_pkg::STATUS_OK;
    halted_d = halted_q;
    case (item_q.func)
      btmu_pkg::FUNC_ADD: begin
        if (full) begin
          status_d = btmu_pkg::STATUS_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      btmu_pkg::FUNC_ENABLE, btmu_pkg::FUNC_DISABLE: begin
        if (!item_q.all_entries && !slot_ok) begin
          status_d = btmu_pkg::STATUS_RANGE;
        end
      end
      btmu_pkg::FUNC_DELETE: begin
        if (item_q.all_entries) begin
          count_d = '0;
        end else if (slot_ok) begin
          count_d = count_q - CW'(1);
        end else begin
          status_d = btmu_pkg::STATUS_RANGE;
        end
      end
      btmu_pkg::FUNC_RESUME: halted_d = 1'b0;
      btmu_pkg::FUNC_HALT:   halted_d = 1'b1;
      default: ;
    endcase
  end

  // Lowest matching index
  always_comb begin
    hit_idx = '0;
    for (int i = MaxEntries - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        hit_idx = IW'(i);
      end
    end
  end
  assign hit_any = |match_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.exec) begin
      ent_q    <= ent_d;
      match_q  <= match_d;
      status_q <= status_d;
    end
    if (cmd_i.finish) begin
      result_q.status      <= status_q;
      result_q.hit         <= hit_any;
      result_q.hit_slot    <= 4'(hit_idx);
      result_q.halted      <= halted_q | hit_any;
      result_q.entry_count <= 5'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      halted_q <= 1'b0;
    end else if (cmd_i.exec) begin
      count_q  <= count_d;
      halted_q <= halted_d;
    end else if (cmd_i.finish && hit_any) begin
      halted_q <= 1'b1;
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

// ===== test/breakpoint_table_match_unit_test.sv =====
`timescale 1ns / 1ps

module breakpoint_table_match_unit_test;

  localparam int unsigned DEPTH = btmu_pkg::MAX_ENTRIES_DEF;
  // func code seven has no command behind it; the block must answer it as a no-op
  localparam logic [2:0] FUNC_UNUSED = 3'd7;

  // random stimulus shapes
  localparam int STYLE_FILL  = 0;  // adds until the table refuses
  localparam int STYLE_RUN   = 1;  // pc checks against live entries, resume after a hit
  localparam int STYLE_EDIT  = 2;  // enable / disable / delete traffic
  localparam int STYLE_NOISE = 3;  // every field fully random

  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned IDLE_LIMIT   = 4000;  // cycles with no beat on either side
  localparam int unsigned DRAIN_CYCLES = 8;     // quiet cycles waited after the last owed answer

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  btmu_pkg::item_t   in_item_i;
  logic              out_valid_o;
  logic              out_stall_i;
  btmu_pkg::result_t out_result_o;

  // Tracks the table, count and halted flag the block should hold, and keeps
  // the answers still owed by the block in order of the accepted commands.
  class breakpoint_tracker;
    btmu_pkg::entry_t  bp_entries[DEPTH];
    int unsigned       entry_total;
    bit                is_halted;
    btmu_pkg::result_t owed_answers[$];
    int unsigned       mismatches;
    int unsigned       answers;
    int unsigned       hits;
    int unsigned       full_refusals;
    int unsigned       range_refusals;

    function new();
      foreach (bp_entries[i]) bp_entries[i] = '0;
      entry_total    = 0;
      is_halted      = 1'b0;
      mismatches     = 0;
      answers        = 0;
      hits           = 0;
      full_refusals  = 0;
      range_refusals = 0;
    endfunction

    function void note_command(btmu_pkg::item_t it);
      btmu_pkg::result_t r;
      int unsigned       i;
      logic              on_value;
      r = '0;
      case (it.func)
        btmu_pkg::FUNC_CHECK: begin
          // no comparison at all while halted; lowest matching slot wins
          if (!is_halted) begin
            for (i = 0; i < entry_total && !r.hit; i++) begin
              if (bp_entries[i].on && bp_entries[i].kind == btmu_pkg::KIND_CODE &&
                  bp_entries[i].addr == it.address) begin
                r.hit      = 1'b1;
                r.hit_slot = i[3:0];
                is_halted  = 1'b1;
              end
            end
          end
        end
        btmu_pkg::FUNC_ADD: begin
          if (entry_total < DEPTH) begin
            bp_entries[entry_total].kind = it.kind;
            bp_entries[entry_total].addr = it.address;
            bp_entries[entry_total].on   = 1'b1;
            entry_total++;
          end else begin
            r.status = btmu_pkg::STATUS_FULL;
          end
        end
        btmu_pkg::FUNC_ENABLE, btmu_pkg::FUNC_DISABLE: begin
          on_value = (it.func == btmu_pkg::FUNC_ENABLE);
          if (it.all_entries) begin
            for (i = 0; i < entry_total; i++) bp_entries[i].on = on_value;
          end else if (it.slot < entry_total) begin
            bp_entries[it.slot].on = on_value;
          end else begin
            r.status = btmu_pkg::STATUS_RANGE;
          end
        end
        btmu_pkg::FUNC_DELETE: begin
          if (it.all_entries) begin
            entry_total = 0;
          end else if (it.slot < entry_total) begin
            // compaction: everything above the slot moves down one place
            for (i = it.slot + 1; i < entry_total; i++) bp_entries[i - 1] = bp_entries[i];
            entry_total--;
          end else begin
            r.status = btmu_pkg::STATUS_RANGE;
          end
        end
        btmu_pkg::FUNC_RESUME: is_halted = 1'b0;
        btmu_pkg::FUNC_HALT:   is_halted = 1'b1;
        default: ;
      endcase
      r.halted      = is_halted;
      r.entry_count = entry_total[4:0];
      owed_answers.push_back(r);
    endfunction

    function void compare_field(string name, logic [4:0] want, logic [4:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(btmu_pkg::result_t got);
      btmu_pkg::result_t want;
      if (owed_answers.size() == 0) begin
        $error("result beat with no command waiting for it");
        mismatches++;
      end else begin
        want = owed_answers.pop_front();
        answers++;
        if (want.hit) hits++;
        if (want.status == btmu_pkg::STATUS_FULL) full_refusals++;
        if (want.status == btmu_pkg::STATUS_RANGE) range_refusals++;
        compare_field("status", 5'(want.status), 5'(got.status));
        compare_field("hit", 5'(want.hit), 5'(got.hit));
        compare_field("hit_slot", 5'(want.hit_slot), 5'(got.hit_slot));
        compare_field("halted", 5'(want.halted), 5'(got.halted));
        compare_field("entry_count", want.entry_count, got.entry_count);
      end
    endfunction
  endclass

  breakpoint_tracker tracker;

  breakpoint_table_match_unit #(
    .MAX_ENTRIES(DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_result_o(out_result_o)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Result side: check every accepted result beat against the oldest answer owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_result(out_result_o);
  end

  // Receiver stall pattern: stretches of a fixed mode, each of random length.
  // Mode 0 never stalls, mode 1 stalls about a third of the time, mode 2 mostly.
  int unsigned stall_mode;
  int unsigned stall_run;

  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_run  <= $urandom_range(20, 120);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 2) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Watchdog: any beat on either side restarts the count.
  int unsigned idle_cycles;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
      $display("breakpoint_table_match_unit_test: errors");
      $finish;
    end
  end

  // Sender pacing: bursts of 1..24 beats, with a random gap, at times empty, between them.
  int unsigned burst_left;
  int unsigned beats_sent;
  logic [15:0] addr_pool[8];

  task automatic send_command(input btmu_pkg::item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      // keep valid high across a zero gap: never lower and raise in one step
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_command(it);
    beats_sent++;
  endtask

  function automatic btmu_pkg::item_t cmd(logic [2:0] func, logic [15:0] address,
                                          logic [1:0] kind, logic [3:0] slot,
                                          logic all_entries);
    btmu_pkg::item_t it;
    it.func        = func;
    it.address     = address;
    it.kind        = kind;
    it.slot        = slot;
    it.all_entries = all_entries;
    return it;
  endfunction

  // mostly a small pool so duplicates and repeat hits happen, sometimes anything
  function automatic logic [15:0] pick_address();
    if ($urandom_range(0, 4) != 0) return addr_pool[3'($urandom_range(0, 7))];
    return 16'($urandom_range(0, 16'hffff));
  endfunction

  // mostly a live slot once the table holds something, otherwise any index
  function automatic logic [3:0] pick_slot();
    int unsigned n;
    n = tracker.entry_total;
    if (n != 0 && $urandom_range(0, 3) != 0) return 4'($urandom_range(0, n - 1));
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic btmu_pkg::item_t make_random_command(int style);
    btmu_pkg::item_t it;
    int unsigned     pick;
    int unsigned     n;
    n = tracker.entry_total;
    pick = $urandom_range(0, 99);
    it = cmd(btmu_pkg::FUNC_CHECK, 16'($urandom_range(0, 16'hffff)), 2'($urandom_range(0, 3)),
             4'($urandom_range(0, 15)), ($urandom_range(0, 7) == 0));
    case (style)
      STYLE_FILL: begin
        it.func    = btmu_pkg::FUNC_ADD;
        it.address = pick_address();
        it.kind    = (pick < 75) ? btmu_pkg::KIND_CODE : 2'($urandom_range(1, 3));
      end
      STYLE_RUN: begin
        if (tracker.is_halted && pick < 35) begin
          it.func = btmu_pkg::FUNC_RESUME;
        end else if (pick < 85) begin
          // aim at a stored address most of the time so checks actually hit
          if (n != 0 && $urandom_range(0, 2) != 0) begin
            it.address = tracker.bp_entries[$urandom_range(0, n - 1)].addr;
          end else begin
            it.address = pick_address();
          end
        end else if (pick < 92) begin
          it.func    = btmu_pkg::FUNC_ADD;
          it.kind    = btmu_pkg::KIND_CODE;
          it.address = pick_address();
        end else if (pick < 96) begin
          it.func = btmu_pkg::FUNC_HALT;
        end else begin
          it.func = (pick < 98) ? btmu_pkg::FUNC_DISABLE : btmu_pkg::FUNC_ENABLE;
          it.slot = pick_slot();
        end
      end
      STYLE_EDIT: begin
        if (pick < 20) begin
          it.func    = btmu_pkg::FUNC_ADD;
          it.address = pick_address();
        end else if (pick < 45) begin
          it.func = btmu_pkg::FUNC_ENABLE;
        end else if (pick < 70) begin
          it.func = btmu_pkg::FUNC_DISABLE;
        end else if (pick < 85) begin
          it.func = btmu_pkg::FUNC_DELETE;
          // whole-table delete stays rare so the table keeps some depth
          it.all_entries = ($urandom_range(0, 15) == 0);
        end else if (pick < 95) begin
          it.address = pick_address();
        end else begin
          it.func = btmu_pkg::FUNC_RESUME;
        end
        it.slot = pick_slot();
      end
      default: begin
        it.func        = 3'($urandom_range(0, 7));
        it.all_entries = 1'($urandom_range(0, 1));
      end
    endcase
    return it;
  endfunction

  initial begin
    int          style;
    int unsigned phase_len;
    int unsigned random_sent;
    int unsigned k;
    int unsigned directed_beats;

    tracker     = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    stall_mode  = 0;
    stall_run   = 0;
    idle_cycles = 0;
    burst_left  = 0;
    beats_sent  = 0;
    random_sent = 0;
    addr_pool[0] = 16'h0000;
    addr_pool[1] = 16'hffff;
    for (k = 2; k < 8; k++) addr_pool[k] = 16'($urandom_range(0, 16'hffff));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    send_command(cmd(btmu_pkg::FUNC_CHECK,   16'h0000, btmu_pkg::KIND_CODE, 4'd0,  1'b0));
    send_command(cmd(btmu_pkg::FUNC_DELETE,  16'h0000, btmu_pkg::KIND_CODE, 4'd0,  1'b0));
    send_command(cmd(btmu_pkg::FUNC_ENABLE,  16'h0000, btmu_pkg::KIND_CODE, 4'd0,  1'b0));
    send_command(cmd(btmu_pkg::FUNC_DISABLE, 16'h0000, btmu_pkg::KIND_CODE, 4'd0,  1'b1));
    send_command(cmd(btmu_pkg::FUNC_ADD,     16'h0000, btmu_pkg::KIND_CODE, 4'd15, 1'b1));
    send_command(cmd(btmu_pkg::FUNC_ADD,     16'hffff, btmu_pkg::KIND_CODE, 4'd0,  1'b0));
    send_command(cmd(btmu_pkg::FUNC_ADD,     16'h1234, 2'd1,                4'd0,  1'b0));
    send_command(cmd(btmu_pkg::FUNC_ADD,     16'h1234, 2'd2,                4'd0,  1'b0));
    send_command(cmd(btmu_pkg::FUNC_ADD,     16'h1234, 2'd3,                4'd0,  1'b0));
    send_command(cmd(btmu_pkg::FUNC_ADD,     16'hffff, btmu_pkg::KIND_CODE, 4'd0,  1'b0));
    send_command(cmd(btmu_pkg::FUNC_CHECK,   16'h1234, btmu_pkg::KIND_CODE, 4'd0,  1'b0));
    send_command(cmd(btmu_pkg::FUNC_CHECK,   16'hffff, 2'd3,                4'd15, 1'b1));
    send_command(cmd(btmu_pkg::FUNC_CHECK,   16'h0000, btmu_pkg::KIND_CODE, 4'd0,  1'b0));
    send_command(cmd(btmu_pkg::FUNC_RESUME,  16'hffff, 2'd3,                4'd15, 1'b1));
    send_command(cmd(btmu_pkg::FUNC_DISABLE, 16'h0000, btmu_pkg::KIND_CODE, 4'd1,  1'b0));
    send_command(cmd(btmu_pkg::FUNC_CHECK,   16'hffff, btmu_pkg::KIND_CODE, 4'd0,  1'b0));
    send_command(cmd(btmu_pkg::FUNC_RESUME,  16'h0000, btmu_pkg::KIND_CODE, 4'd0,  1'b0));
    send_command(cmd(btmu_pkg::FUNC_DISABLE, 16'h0000, btmu_pkg::KIND_CODE, 4'd15, 1'b1));
    send_command(cmd(btmu_pkg::FUNC_CHECK,   16'h0000, btmu_pkg::KIND_CODE, 4'd0,  1'b0));
    send_command(cmd(btmu_pkg::FUNC_ENABLE,  16'h0000, btmu_pkg::KIND_CODE, 4'd0,  1'b1));
    send_command(cmd(btmu_pkg::FUNC_DELETE,  16'h0000, btmu_pkg::KIND_CODE, 4'd0,  1'b0));
    send_command(cmd(btmu_pkg::FUNC_CHECK,   16'hffff, btmu_pkg::KIND_CODE, 4'd0,  1'b0));
    send_command(cmd(btmu_pkg::FUNC_HALT,    16'h5a5a, 2'd2,                4'd7,  1'b1));
    send_command(cmd(FUNC_UNUSED,            16'ha5a5, 2'd1,                4'd8,  1'b1));
    send_command(cmd(btmu_pkg::FUNC_RESUME,  16'h0000, btmu_pkg::KIND_CODE, 4'd0,  1'b0));
    send_command(cmd(btmu_pkg::FUNC_DELETE,  16'h0000, btmu_pkg::KIND_CODE, 4'd15, 1'b0));
    send_command(cmd(btmu_pkg::FUNC_DELETE,  16'h0000, btmu_pkg::KIND_CODE, 4'd9,  1'b1));
    directed_beats = beats_sent;

    // --- random part, in phases of one style each ---
    while (random_sent < RANDOM_ITEMS) begin
      k = $urandom_range(0, 99);
      if (k < 15)      style = STYLE_FILL;
      else if (k < 60) style = STYLE_RUN;
      else if (k < 85) style = STYLE_EDIT;
      else             style = STYLE_NOISE;
      // a fill phase runs past full so the refusal is seen a few times
      if (style == STYLE_FILL) phase_len = (DEPTH - tracker.entry_total) + $urandom_range(1, 3);
      else                     phase_len = $urandom_range(10, 60);
      for (k = 0; k < phase_len && random_sent < RANDOM_ITEMS; k++) begin
        send_command(make_random_command(style));
        random_sent++;
      end
    end
    in_valid_i <= 1'b0;

    // drain: every owed answer back, then a few quiet cycles for stray beats
    while (tracker.owed_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d command beats (%0d directed), %0d results checked",
             beats_sent, directed_beats, tracker.answers);
    $display("  %0d breakpoint hits, %0d adds to a full table, %0d out-of-range slots",
             tracker.hits, tracker.full_refusals, tracker.range_refusals);
    if (tracker.mismatches == 0) begin
      $display("breakpoint_table_match_unit_test: clean");
    end else begin
      $display("breakpoint_table_match_unit_test: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/btmu_pkg.sv
sv/btmu_ctrl.sv
sv/btmu_dp.sv
sv/breakpoint_table_match_unit.sv
test/breakpoint_table_match_unit_test.sv
